// ----- rtl/rfor_pkg.sv -----
// Shared types and codes for the rectangle fill and outline rasteriser.
package rfor_pkg;

  // Request and rectangle kind codes as they arrive on the command port.
  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_DRAW     = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;
  localparam logic [1:0] KIND_OUTLINE = 2'd0;
  localparam logic [1:0] KIND_FILLED  = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BOARD_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_BOARD_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG_CHAR      = 2'd2;

  localparam logic [9:0] BOARD_SIZE_RESET = 10'd512;
  localparam logic [7:0] BG_CHAR_RESET    = 8'd32;

  // Width of an edge position once a size has been added to it.
  localparam int unsigned EDGE_W = 19;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_DRAW,
    OP_REJECT,
    OP_READ,
    OP_NOP
  } op_e;

  // One classified command as it travels from the front end to the engine.
  typedef struct packed {
    op_e                      op;
    logic                     filled;
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] left_in;
    logic signed [EDGE_W-1:0] right;
    logic signed [EDGE_W-1:0] right_in;
    logic signed [EDGE_W-1:0] top;
    logic signed [EDGE_W-1:0] top_in;
    logic signed [EDGE_W-1:0] bottom;
    logic signed [EDGE_W-1:0] bottom_in;
    logic [7:0]               ch;
    logic [8:0]               col;
    logic [8:0]               row;
    logic                     in_store;
  } cmd_t;

endpackage

// ----- rtl/rfor_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module rfor_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rfor_fifo.sv -----
// Short command queue between the front end and the raster engine.
module rfor_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rfor_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rfor_pkg::cmd_t data_o,
  output logic          empty_o
);
  import rfor_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);

endmodule

// ----- rtl/rfor_front.sv -----
// Command front end: takes a command beat, classifies it and precomputes edges.
module rfor_front #(
  parameter int unsigned MAX_COLS  = 512,
  parameter int unsigned MAX_ROWS  = 512,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [1:0]     req_type_i,
  input  logic [8:0]     cell_col_i,
  input  logic [8:0]     cell_row_i,
  input  logic [1:0]     rect_kind_i,
  input  logic [17:0]    rect_left_i,
  input  logic [17:0]    rect_top_i,
  input  logic [17:0]    rect_width_i,
  input  logic [17:0]    rect_height_i,
  input  logic [7:0]     rect_char_i,
  output logic           push_o,
  output rfor_pkg::cmd_t cmd_o,
  input  logic           full_i
);
  import rfor_pkg::*;

  localparam logic [EDGE_W-1:0] ONE = EDGE_W'(1 << FRAC_BITS);

  logic       valid_q;
  cmd_t       cmd_q, cmd_d;
  logic       accept;
  logic [EDGE_W-1:0] left_x, top_x, width_x, height_x;
  logic       bad_size;

  assign accept = start_i && !valid_q;

  always_comb begin
    left_x   = {rect_left_i[17], rect_left_i};
    top_x    = {rect_top_i[17], rect_top_i};
    width_x  = {rect_width_i[17], rect_width_i};
    height_x = {rect_height_i[17], rect_height_i};
    bad_size = rect_width_i[17] || (rect_width_i == '0) ||
               rect_height_i[17] || (rect_height_i == '0);

    cmd_d           = '0;
    cmd_d.filled    = (rect_kind_i == KIND_FILLED);
    cmd_d.left      = left_x;
    cmd_d.left_in   = left_x + ONE;
    cmd_d.right     = left_x + width_x;
    cmd_d.right_in  = left_x + width_x - ONE;
    cmd_d.top       = top_x;
    cmd_d.top_in    = top_x + ONE;
    cmd_d.bottom    = top_x + height_x;
    cmd_d.bottom_in = top_x + height_x - ONE;
    cmd_d.ch        = rect_char_i;
    cmd_d.col       = cell_col_i;
    cmd_d.row       = cell_row_i;
    cmd_d.in_store  = (32'(cell_col_i) < MAX_COLS) && (32'(cell_row_i) < MAX_ROWS);

    unique case (req_type_i)
      REQ_CLEAR: cmd_d.op = OP_CLEAR;
      REQ_DRAW: begin
        if ((rect_kind_i != KIND_OUTLINE && rect_kind_i != KIND_FILLED) || bad_size) begin
          cmd_d.op = OP_REJECT;
        end else begin
          cmd_d.op = OP_DRAW;
        end
      end
      REQ_READ: cmd_d.op = OP_READ;
      default:  cmd_d.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  assign push_o = valid_q && !full_i;
  assign cmd_o  = cmd_q;
  assign busy_o = valid_q;

endmodule

// ----- rtl/rfor_back.sv -----
// Raster engine: scans the active area for clear and draw, and serves reads.
module rfor_back #(
  parameter int unsigned MAX_COLS  = 512,
  parameter int unsigned MAX_ROWS  = 512,
  parameter int unsigned FRAC_BITS = 8,
  localparam int unsigned ADDR_W =
    (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfor_pkg::cmd_t    cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic [9:0]        board_width_i,
  input  logic [9:0]        board_height_i,
  input  logic [7:0]        bg_char_i,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              done_o,
  output logic [7:0]        cell_char_o,
  output logic              status_o
);
  import rfor_pkg::*;

  localparam int unsigned CI_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CC_W  = $clog2(MAX_COLS + 1);
  localparam int unsigned RC_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned POS_W = ((CI_W > RI_W) ? CI_W : RI_W) + FRAC_BITS;
  localparam int unsigned CMP_W = ((POS_W > EDGE_W) ? POS_W : EDGE_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_ISSUE,
    ST_RD_DONE
  } state_e;

  state_e            state_q;
  logic              clear_q, filled_q;
  logic [EDGE_W-1:0] left_q, left_in_q, right_q, right_in_q;
  logic [EDGE_W-1:0] top_q, top_in_q, bottom_q, bottom_in_q;
  logic [7:0]        ch_q;
  logic [CI_W-1:0]   col_q;
  logic [RI_W-1:0]   row_q;
  logic [CC_W-1:0]   cols_q, cols;
  logic [RC_W-1:0]   rows_q, rows;
  logic [ADDR_W-1:0] row_base_q, rd_addr_q;
  logic              done_q, status_q;
  logic [7:0]        cell_char_q;

  logic signed [CMP_W-1:0] x_pos, y_pos;
  logic              in_x, in_y, edge_x, edge_y, paint, last_col, last_row;

  function automatic logic signed [CMP_W-1:0] sx(input logic [EDGE_W-1:0] v);
    return {{(CMP_W - EDGE_W){v[EDGE_W-1]}}, v};
  endfunction

  assign cols = (32'(board_width_i) > MAX_COLS) ? CC_W'(MAX_COLS) : CC_W'(board_width_i);
  assign rows = (32'(board_height_i) > MAX_ROWS) ? RC_W'(MAX_ROWS) : RC_W'(board_height_i);

  // Cell (col,row) sits at the integer point, so its fixed point position is
  // the index shifted up by the fraction width.
  always_comb begin
    x_pos  = CMP_W'({col_q, {FRAC_BITS{1'b0}}});
    y_pos  = CMP_W'({row_q, {FRAC_BITS{1'b0}}});
    in_x   = (x_pos >= sx(left_q)) && (x_pos <= sx(right_q));
    in_y   = (y_pos >= sx(top_q)) && (y_pos <= sx(bottom_q));
    edge_x = (x_pos < sx(left_in_q)) || (x_pos > sx(right_in_q));
    edge_y = (y_pos < sx(top_in_q)) || (y_pos > sx(bottom_in_q));
    paint  = clear_q || (in_x && in_y && (filled_q || edge_x || edge_y));
  end

  assign last_col = ((CC_W'(col_q) + CC_W'(1)) == cols_q);
  assign last_row = ((RC_W'(row_q) + RC_W'(1)) == rows_q);

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign ram_we_o    = (state_q == ST_SCAN) && paint;
  assign ram_waddr_o = row_base_q + ADDR_W'(col_q);
  assign ram_wdata_o = ch_q;
  assign ram_raddr_o = rd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clear_q     <= 1'b0;
      filled_q    <= 1'b0;
      left_q      <= '0;
      left_in_q   <= '0;
      right_q     <= '0;
      right_in_q  <= '0;
      top_q       <= '0;
      top_in_q    <= '0;
      bottom_q    <= '0;
      bottom_in_q <= '0;
      ch_q        <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cols_q      <= '0;
      rows_q      <= '0;
      row_base_q  <= '0;
      rd_addr_q   <= '0;
      done_q      <= 1'b0;
      status_q    <= 1'b0;
      cell_char_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            status_q    <= 1'b0;
            cell_char_q <= '0;
            unique case (cmd_i.op) inside
              OP_CLEAR, OP_DRAW: begin
                clear_q     <= (cmd_i.op == OP_CLEAR);
                filled_q    <= cmd_i.filled;
                left_q      <= cmd_i.left;
                left_in_q   <= cmd_i.left_in;
                right_q     <= cmd_i.right;
                right_in_q  <= cmd_i.right_in;
                top_q       <= cmd_i.top;
                top_in_q    <= cmd_i.top_in;
                bottom_q    <= cmd_i.bottom;
                bottom_in_q <= cmd_i.bottom_in;
                ch_q        <= (cmd_i.op == OP_CLEAR) ? bg_char_i : cmd_i.ch;
                cols_q      <= cols;
                rows_q      <= rows;
                col_q       <= '0;
                row_q       <= '0;
                row_base_q  <= '0;
                if (cols == '0 || rows == '0) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              OP_REJECT: begin
                status_q <= 1'b1;
                done_q   <= 1'b1;
              end
              OP_READ: begin
                if (cmd_i.in_store) begin
                  rd_addr_q <= ADDR_W'(32'(cmd_i.row) * MAX_COLS + 32'(cmd_i.col));
                  state_q   <= ST_RD_ISSUE;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (last_col) begin
            col_q <= '0;
            if (last_row) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              row_q      <= row_q + 1'b1;
              row_base_q <= row_base_q + ADDR_W'(MAX_COLS);
            end
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        ST_RD_ISSUE: begin
          state_q <= ST_RD_DONE;
        end
        ST_RD_DONE: begin
          cell_char_q <= ram_rdata_i;
          done_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o      = done_q;
  assign cell_char_o = cell_char_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/rect_fill_outline_raster.sv -----
// Top level of the character frame buffer with clear, rectangle draw and read.
//
// Commands are taken on start while busy is low; each one gives exactly one
// result beat on done_o, in command order, held for a single cycle, and the
// receiver cannot stall it. A clear or draw walks the active area one cell
// per cycle through the single write port of the frame store. The front end
// holds one command and a two-entry queue holds more, so new commands are
// taken while a long scan is still running. The frame store is not cleared
// after reset: issue a clear before reading cells.
module rect_fill_outline_raster #(
  parameter int unsigned MAX_COLS  = 512,
  parameter int unsigned MAX_ROWS  = 512,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [8:0]  cell_col_i,
  input  logic [8:0]  cell_row_i,
  input  logic [1:0]  rect_kind_i,
  input  logic [17:0] rect_left_i,
  input  logic [17:0] rect_top_i,
  input  logic [17:0] rect_width_i,
  input  logic [17:0] rect_height_i,
  input  logic [7:0]  rect_char_i,
  output logic        done_o,
  output logic [7:0]  cell_char_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i
);
  import rfor_pkg::*;

  localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  logic [9:0]        board_width_q, board_height_q;
  logic [7:0]        bg_char_q;
  cmd_t              front_cmd, queue_cmd;
  logic              push, full, pop, empty;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_width_q  <= BOARD_SIZE_RESET;
      board_height_q <= BOARD_SIZE_RESET;
      bg_char_q      <= BG_CHAR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOARD_WIDTH:  board_width_q  <= cfg_wdata_i;
        CFG_BOARD_HEIGHT: board_height_q <= cfg_wdata_i;
        CFG_BG_CHAR:      bg_char_q      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  rfor_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .req_type_i    (req_type_i),
    .cell_col_i    (cell_col_i),
    .cell_row_i    (cell_row_i),
    .rect_kind_i   (rect_kind_i),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .rect_char_i   (rect_char_i),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .full_i        (full)
  );

  rfor_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_cmd),
    .empty_o (empty)
  );

  rfor_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (queue_cmd),
    .empty_i        (empty),
    .pop_o          (pop),
    .board_width_i  (board_width_q),
    .board_height_i (board_height_q),
    .bg_char_i      (bg_char_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .done_o         (done_o),
    .cell_char_o    (cell_char_o),
    .status_o       (status_o)
  );

  rfor_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
